[sv/qdav_pkg.sv]
// Shared widths, pipeline depths and the arctangent table of the angular velocity block.
package qdav_pkg;

	// Field widths of the streaming words and of the register port.
	localparam int QW     = 16;
	localparam int DTW    = 20;
	localparam int OW     = 32;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Register word index (paddr bit 2).
	localparam logic REG_MIN_DT = 1'b0;

	// Reset value of the minimum time step.
	localparam logic [DTW-1:0] MIN_DT_RST = 20'd1;

	// Identity w component in Q2.14.
	localparam logic signed [QW-1:0] ONE_Q14 = 16'sd16384;

	// Stage counts of the iterative sections.
	localparam int SQ_N = 31;   // square root, one result bit per stage
	localparam int QA_N = 32;   // normalising divide
	localparam int CS_N = 31;   // CORDIC vectoring
	localparam int QB_N = 46;   // angle scaling divide
	localparam int QC_N = 32;   // divide by the time step

	// atan(2^-i) in Q30; the first entry is pi/4.
	localparam logic [29:0] ATAN_Q30 [CS_N] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128,
		30'd64,        30'd32,        30'd16,        30'd8,
		30'd4,         30'd2,         30'd1
	};

endpackage

[sv/qdav_if.sv]
// Streaming interfaces for rotation pair words and angular velocity words.
interface qdav_in_if;
	import qdav_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [QW-1:0]  prev_qx;
	logic signed [QW-1:0]  prev_qy;
	logic signed [QW-1:0]  prev_qz;
	logic signed [QW-1:0]  prev_qw;
	logic signed [QW-1:0]  cur_qx;
	logic signed [QW-1:0]  cur_qy;
	logic signed [QW-1:0]  cur_qz;
	logic signed [QW-1:0]  cur_qw;
	logic [DTW-1:0]        delta_time;

	modport source (output valid, prev_qx, prev_qy, prev_qz, prev_qw,
		cur_qx, cur_qy, cur_qz, cur_qw, delta_time, input ready);
	modport sink (input valid, prev_qx, prev_qy, prev_qz, prev_qw,
		cur_qx, cur_qy, cur_qz, cur_qw, delta_time, output ready);
endinterface

interface qdav_out_if;
	import qdav_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [OW-1:0]  omega_x;
	logic signed [OW-1:0]  omega_y;
	logic signed [OW-1:0]  omega_z;
	logic                  time_too_small;

	modport source (output valid, omega_x, omega_y, omega_z, time_too_small, input ready);
	modport sink (input valid, omega_x, omega_y, omega_z, time_too_small, output ready);
endinterface

[sv/quat_delta_angular_velocity.sv]
// Angular velocity from the change between two rotation quaternions, fully pipelined.
//
//  Channel     Direction  Handshake          Carries
//  rot_in      in         valid / ready      two Q2.14 quaternions and a time step
//  omega_out   out        valid / ready      Q16.16 angular velocity and a flag
//  APB         in         psel / penable     min_delta_time at byte address 0
//
// One word enters per cycle while the pipeline is not halted; the depth is set
// by the bit-per-stage square roots, dividers and the CORDIC vectoring chain.
// The whole pipeline advances together: it halts only while the last stage holds a
// word that the sink has not taken, and a valid bit travels with every stage.
// Reset clears the valid bits and sets min_delta_time to one.
module quat_delta_angular_velocity (
	input  logic                         clk,
	input  logic                         arst_n,
	qdav_in_if.sink                      rot_in,
	qdav_out_if.source                   omega_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qdav_pkg::ADDR_W-1:0]  paddr,
	input  logic [qdav_pkg::DATA_W-1:0]  pwdata,
	output logic [qdav_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import qdav_pkg::*;

	// Total depth: five front stages, then each section with its entry register.
	localparam int NST = 5 + (SQ_N + 1) + (QA_N + 1) + 2 + (SQ_N + 1) + (CS_N + 1) + 1
		+ (QB_N + 1) + 1 + (QC_N + 1) + 1;

	// Square root step state: radicand remainder and partial root.
	typedef struct packed {
		logic [61:0] v;
		logic [62:0] rt;
	} sq_t;

	// Side data carried through the first square root.
	typedef struct packed {
		logic             tsm;
		logic [DTW-1:0]   dt;
		logic [3:0]       neg;
		logic [3:0][29:0] mag;
	} fa_t;

	// Normalising divide, four lanes sharing the root as divisor.
	typedef struct packed {
		logic [3:0][60:0] rem;
		logic [3:0][31:0] q;
		logic [30:0]      den;
		logic             tsm;
		logic [DTW-1:0]   dt;
		logic [3:0]       neg;
	} da_t;

	// Unit delta and what follows it through the back half.
	typedef struct packed {
		logic             tsm;
		logic [DTW-1:0]   dt;
		logic             tiny;
		logic [2:0]       us;
		logic [2:0][30:0] um;
		logic [30:0]      w;
		logic [30:0]      sinh;
	} bk_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
	} cr_t;

	typedef struct packed {
		logic [2:0][62:0] rem;
		logic [2:0][45:0] q;
		logic [2:0]       ovf;
	} db_t;

	typedef struct packed {
		logic [2:0][53:0] rem;
		logic [2:0][31:0] q;
		logic [2:0]       ovf;
		logic [2:0]       neg;
		logic             tsm;
		logic [DTW-1:0]   dt;
	} dc_t;

	// One non-restoring-free step of the bitwise integer square root.
	function automatic sq_t sq_step(sq_t a, int k);
		sq_t         r;
		logic [62:0] bitv;
		logic [62:0] trial;
		bitv  = 63'd1 << (2 * k);
		trial = a.rt + bitv;
		if ({1'b0, a.v} >= trial) begin
			r.v  = 62'({1'b0, a.v} - trial);
			r.rt = (a.rt >> 1) + bitv;
		end else begin
			r.v  = a.v;
			r.rt = a.rt >> 1;
		end
		return r;
	endfunction

	// Restoring divide step at quotient bit k: {quotient bit, new remainder}.
	function automatic logic [64:0] div_step(logic [63:0] rem, logic [63:0] den, int k);
		if ((rem >> k) >= den) begin
			return {1'b1, rem - (den << k)};
		end
		return {1'b0, rem};
	endfunction

	// One CORDIC vectoring rotation; shifts floor.
	function automatic cr_t cr_step(cr_t a, int i);
		cr_t                r;
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		x  = a.x;
		y  = a.y;
		xs = x >>> i;
		ys = y >>> i;
		if (y > 34'sd0) begin
			r.x = x + ys;
			r.y = y - xs;
			r.z = a.z + 33'(ATAN_Q30[i]);
		end else begin
			r.x = x - ys;
			r.y = y + xs;
			r.z = a.z - 33'(ATAN_Q30[i]);
		end
		return r;
	endfunction

	logic               en;
	logic [NST-1:0]     vld_s;
	logic [DTW-1:0]     min_dt_q;

	logic signed [15:0] p [4];
	logic signed [15:0] c [4];

	logic signed [31:0] pr_s1 [4][4];
	logic               tsm_s1;
	logic [DTW-1:0]     dt_s1;
	logic signed [33:0] d_s2 [4];
	logic               tsm_s2;
	logic [DTW-1:0]     dt_s2;
	logic [32:0]        mag3 [4];
	logic [32:0]        mor3;
	logic [5:0]         lead3;
	logic [32:0]        mag_s3 [4];
	logic [3:0]         neg_s3;
	logic [5:0]         lead_s3;
	logic               tsm_s3;
	logic [DTW-1:0]     dt_s3;
	logic [32:0]        sh4 [4];
	logic [29:0]        mag_s4 [4];
	logic [3:0]         neg_s4;
	logic               tsm_s4;
	logic [DTW-1:0]     dt_s4;
	logic [59:0]        sq_s5 [4];
	logic [29:0]        mag_s5 [4];
	logic [3:0]         neg_s5;
	logic               tsm_s5;
	logic [DTW-1:0]     dt_s5;

	sq_t                sqa_s [SQ_N+1];
	fa_t                sqa_c [SQ_N+1];
	da_t                da_s  [QA_N+1];
	bk_t                u_s;
	logic [61:0]        w2_s;
	bk_t                w2c_s;
	sq_t                sqb_s [SQ_N+1];
	bk_t                sqb_c [SQ_N+1];
	cr_t                cr_s  [CS_N+1];
	bk_t                cr_c  [CS_N+1];
	logic [61:0]        prod_s [3];
	bk_t                mul_s;
	db_t                db_s  [QB_N+1];
	bk_t                db_c  [QB_N+1];
	logic [45:0]        am_s [3];
	logic [2:0]         as_s;
	logic               tsm_sa;
	logic [DTW-1:0]     dt_sa;
	dc_t                dc_s  [QC_N+1];
	logic [OW-1:0]      om_s [3];
	logic               tsm_so;

	// ---------------------------------------------------------------------
	// Register port. Only one register; writes to any other word are dropped.
	// ---------------------------------------------------------------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MIN_DT) ? DATA_W'(min_dt_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dt_q <= MIN_DT_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_MIN_DT) begin
			min_dt_q <= pwdata[DTW-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Flow control. Every stage moves together; a word waiting at the output
	// freezes the pipe, so nothing is dropped or duplicated.
	// ---------------------------------------------------------------------
	assign en           = !vld_s[NST-1] || omega_out.ready;
	assign rot_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], rot_in.valid};
		end
	end

	// ---------------------------------------------------------------------
	// Front end: a zero quaternion stands for the identity, then the sixteen
	// partial products of cur * conj(prev).
	// ---------------------------------------------------------------------
	always_comb begin
		p[0] = rot_in.prev_qx;
		p[1] = rot_in.prev_qy;
		p[2] = rot_in.prev_qz;
		p[3] = rot_in.prev_qw;
		c[0] = rot_in.cur_qx;
		c[1] = rot_in.cur_qy;
		c[2] = rot_in.cur_qz;
		c[3] = rot_in.cur_qw;
		if (p[0] == '0 && p[1] == '0 && p[2] == '0 && p[3] == '0) begin
			p[3] = ONE_Q14;
		end
		if (c[0] == '0 && c[1] == '0 && c[2] == '0 && c[3] == '0) begin
			c[3] = ONE_Q14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					pr_s1[i][j] <= 32'(c[i]) * 32'(p[j]);
				end
			end
			tsm_s1 <= rot_in.delta_time <= min_dt_q;
			dt_s1  <= rot_in.delta_time;
		end
	end

	// Delta components in Q6.28, order x, y, z, w.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2[3] <= 34'(pr_s1[3][3]) + 34'(pr_s1[0][0]) + 34'(pr_s1[1][1])
				+ 34'(pr_s1[2][2]);
			d_s2[0] <= -34'(pr_s1[3][0]) + 34'(pr_s1[0][3]) - 34'(pr_s1[1][2])
				+ 34'(pr_s1[2][1]);
			d_s2[1] <= -34'(pr_s1[3][1]) + 34'(pr_s1[0][2]) + 34'(pr_s1[1][3])
				- 34'(pr_s1[2][0]);
			d_s2[2] <= -34'(pr_s1[3][2]) - 34'(pr_s1[0][1]) + 34'(pr_s1[1][0])
				+ 34'(pr_s1[2][3]);
			tsm_s2  <= tsm_s1;
			dt_s2   <= dt_s1;
		end
	end

	// Magnitudes and the position of the leading one of the largest; the OR of
	// all magnitudes has its top bit where the largest one does.
	always_comb begin
		mor3  = '0;
		lead3 = '0;
		for (int i = 0; i < 4; i++) begin
			mag3[i] = (d_s2[i] < 0) ? 33'(-d_s2[i]) : 33'(d_s2[i]);
			mor3    = mor3 | mag3[i];
		end
		for (int k = 0; k < 33; k++) begin
			if (mor3[k]) begin
				lead3 = 6'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mag_s3[i] <= mag3[i];
				neg_s3[i] <= d_s2[i] < 0;
			end
			lead_s3 <= lead3;
			tsm_s3  <= tsm_s2;
			dt_s3   <= dt_s2;
		end
	end

	// Common shift that puts the largest magnitude in [2^29, 2^30).
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (lead_s3 >= 6'd29) begin
				sh4[i] = mag_s3[i] >> (lead_s3 - 6'd29);
			end else begin
				sh4[i] = mag_s3[i] << (6'd29 - lead_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mag_s4[i] <= sh4[i][29:0];
			end
			neg_s4 <= neg_s3;
			tsm_s4 <= tsm_s3;
			dt_s4  <= dt_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s5[i]  <= 60'(mag_s4[i]) * 60'(mag_s4[i]);
				mag_s5[i] <= mag_s4[i];
			end
			neg_s5 <= neg_s4;
			tsm_s5 <= tsm_s4;
			dt_s5  <= dt_s4;
		end
	end

	// ---------------------------------------------------------------------
	// Norm: sum of squares, then one root bit per stage.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s[0].v  <= 62'(sq_s5[0]) + 62'(sq_s5[1]) + 62'(sq_s5[2]) + 62'(sq_s5[3]);
			sqa_s[0].rt <= '0;
			sqa_c[0].tsm <= tsm_s5;
			sqa_c[0].dt  <= dt_s5;
			sqa_c[0].neg <= neg_s5;
			for (int i = 0; i < 4; i++) begin
				sqa_c[0].mag[i] <= mag_s5[i];
			end
			for (int j = 0; j < SQ_N; j++) begin
				sqa_s[j+1] <= sq_step(sqa_s[j], SQ_N - 1 - j);
				sqa_c[j+1] <= sqa_c[j];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Unit delta: round(mag * 2^30 / s), four lanes, one quotient bit a stage.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		logic [30:0] s;
		logic [64:0] t;
		if (en) begin
			s = sqa_s[SQ_N].rt[30:0];
			if (s == '0) begin
				s = 31'd1;
			end
			for (int i = 0; i < 4; i++) begin
				da_s[0].rem[i] <= (61'(sqa_c[SQ_N].mag[i]) << 30) + 61'(s >> 1);
				da_s[0].q[i]   <= '0;
			end
			da_s[0].den <= s;
			da_s[0].tsm <= sqa_c[SQ_N].tsm;
			da_s[0].dt  <= sqa_c[SQ_N].dt;
			da_s[0].neg <= sqa_c[SQ_N].neg;
			for (int j = 0; j < QA_N; j++) begin
				da_s[j+1].den <= da_s[j].den;
				da_s[j+1].tsm <= da_s[j].tsm;
				da_s[j+1].dt  <= da_s[j].dt;
				da_s[j+1].neg <= da_s[j].neg;
				for (int i = 0; i < 4; i++) begin
					t = div_step(64'(da_s[j].rem[i]), 64'(da_s[j].den), QA_N - 1 - j);
					da_s[j+1].rem[i] <= t[60:0];
					da_s[j+1].q[i]   <= da_s[j].q[i] | (32'(t[64]) << (QA_N - 1 - j));
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Shortest rotation: flip all signs when w is negative, clamp w to one.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		logic flip;
		if (en) begin
			flip = da_s[QA_N].neg[3] && da_s[QA_N].q[3] != '0;
			for (int i = 0; i < 3; i++) begin
				u_s.um[i] <= da_s[QA_N].q[i][30:0];
				u_s.us[i] <= (da_s[QA_N].neg[i] && da_s[QA_N].q[i] != '0) ^ flip;
			end
			u_s.w    <= (da_s[QA_N].q[3] > 32'h4000_0000) ? 31'h4000_0000
				: da_s[QA_N].q[3][30:0];
			u_s.tsm  <= da_s[QA_N].tsm;
			u_s.dt   <= da_s[QA_N].dt;
			u_s.tiny <= 1'b0;
			u_s.sinh <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w2_s  <= 62'(u_s.w) * 62'(u_s.w);
			w2c_s <= u_s;
		end
	end

	// ---------------------------------------------------------------------
	// sin^2 of the half angle in Q60, its root, and the small-angle test.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		logic [60:0] sin2;
		bk_t         side;
		if (en) begin
			sin2      = (61'd1 << 60) - 61'(w2_s);
			side      = w2c_s;
			side.tiny = sin2 <= 61'd1048576;
			sqb_s[0].v  <= 62'(sin2);
			sqb_s[0].rt <= '0;
			sqb_c[0]    <= side;
			for (int j = 0; j < SQ_N; j++) begin
				sqb_s[j+1] <= sq_step(sqb_s[j], SQ_N - 1 - j);
				sqb_c[j+1] <= sqb_c[j];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Half angle by CORDIC vectoring of (w, sin) in Q30.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		bk_t side;
		if (en) begin
			side      = sqb_c[SQ_N];
			side.sinh = sqb_s[SQ_N].rt[30:0];
			cr_s[0].x <= 34'(sqb_c[SQ_N].w);
			cr_s[0].y <= 34'(sqb_s[SQ_N].rt[30:0]);
			cr_s[0].z <= '0;
			cr_c[0]   <= side;
			for (int j = 0; j < CS_N; j++) begin
				cr_s[j+1] <= cr_step(cr_s[j], j);
				cr_c[j+1] <= cr_c[j];
			end
		end
	end

	// Clamp the angle at zero and scale each axis component by it.
	always_ff @(posedge clk) begin
		logic [30:0] half;
		bk_t         side;
		if (en) begin
			half = (cr_s[CS_N].z < 0) ? '0 : cr_s[CS_N].z[30:0];
			for (int i = 0; i < 3; i++) begin
				prod_s[i] <= 62'(cr_c[CS_N].um[i]) * 62'(half);
			end
			side = cr_c[CS_N];
			if (side.sinh == '0) begin
				side.sinh = 31'd1;
			end
			mul_s <= side;
		end
	end

	// ---------------------------------------------------------------------
	// Axis times angle: round(|u| * half / sin). A quotient past 2^46 always
	// saturates later, so it is only flagged.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		logic [62:0] num;
		logic [64:0] t;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num = 63'(prod_s[i]) + 63'(mul_s.sinh >> 1);
				db_s[0].rem[i] <= num;
				db_s[0].q[i]   <= '0;
				db_s[0].ovf[i] <= (num >> QB_N) >= 63'(mul_s.sinh);
			end
			db_c[0] <= mul_s;
			for (int j = 0; j < QB_N; j++) begin
				db_c[j+1]     <= db_c[j];
				db_s[j+1].ovf <= db_s[j].ovf;
				for (int i = 0; i < 3; i++) begin
					t = div_step(64'(db_s[j].rem[i]), 64'(db_c[j].sinh), QB_N - 1 - j);
					db_s[j+1].rem[i] <= t[62:0];
					db_s[j+1].q[i]   <= db_s[j].q[i] | (46'(t[64]) << (QB_N - 1 - j));
				end
			end
		end
	end

	// Small rotations use the vector part directly (2*xyz/dt).
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (db_c[QB_N].tiny) begin
					am_s[i] <= 46'(db_c[QB_N].um[i]);
				end else if (db_s[QB_N].ovf[i]) begin
					am_s[i] <= '1;
				end else begin
					am_s[i] <= db_s[QB_N].q[i];
				end
			end
			as_s   <= db_c[QB_N].us;
			tsm_sa <= db_c[QB_N].tsm;
			dt_sa  <= db_c[QB_N].dt;
		end
	end

	// ---------------------------------------------------------------------
	// Divide by the time step: round(|a| * 2^7 / dt), Q30 to Q16.16.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		logic [53:0] num;
		logic [64:0] t;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num = (54'(am_s[i]) << 7) + 54'(dt_sa >> 1);
				dc_s[0].rem[i] <= num;
				dc_s[0].q[i]   <= '0;
				dc_s[0].ovf[i] <= (num >> QC_N) >= 54'(dt_sa);
			end
			dc_s[0].neg <= as_s;
			dc_s[0].tsm <= tsm_sa;
			dc_s[0].dt  <= dt_sa;
			for (int j = 0; j < QC_N; j++) begin
				dc_s[j+1].ovf <= dc_s[j].ovf;
				dc_s[j+1].neg <= dc_s[j].neg;
				dc_s[j+1].tsm <= dc_s[j].tsm;
				dc_s[j+1].dt  <= dc_s[j].dt;
				for (int i = 0; i < 3; i++) begin
					t = div_step(64'(dc_s[j].rem[i]), 64'(dc_s[j].dt), QC_N - 1 - j);
					dc_s[j+1].rem[i] <= t[53:0];
					dc_s[j+1].q[i]   <= dc_s[j].q[i] | (32'(t[64]) << (QC_N - 1 - j));
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output word: saturate, or force zero when the time step is too small.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		logic [31:0] m;
		logic        big;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m = dc_s[QC_N].q[i];
				if (dc_s[QC_N].tsm) begin
					om_s[i] <= '0;
				end else if (dc_s[QC_N].neg[i]) begin
					big     = dc_s[QC_N].ovf[i] || m[31];
					om_s[i] <= big ? 32'h8000_0000 : -m;
				end else begin
					big     = dc_s[QC_N].ovf[i] || m >= 32'h7FFF_FFFF;
					om_s[i] <= big ? 32'h7FFF_FFFF : m;
				end
			end
			tsm_so <= dc_s[QC_N].tsm;
		end
	end

	assign omega_out.valid          = vld_s[NST-1];
	assign omega_out.omega_x        = om_s[0];
	assign omega_out.omega_y        = om_s[1];
	assign omega_out.omega_z        = om_s[2];
	assign omega_out.time_too_small = tsm_so;

endmodule
